/* rtl/mcx_pkg.sv */
// ----------------------------------------------------------------------------
// mcx_pkg: shared types and constants for the line-C execute block
// Holds the channel payload structs, the decoded operation and the opmode codes.
// ----------------------------------------------------------------------------
package mcx_pkg;

  // Payload of one instruction transfer.
  typedef struct packed {
    logic [15:0] opcode;
    logic [31:0] mem_operand;
  } in_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic        illegal;
    logic        mem_write;
    logic [31:0] mem_data;
    logic [3:0]  flags_nzvc;
  } out_t;

  // Operation classes produced by the decoder.
  typedef enum logic [2:0] {
    OP_AND_TO_D,
    OP_AND_TO_M,
    OP_MULU,
    OP_MULS,
    OP_EXG_DD,
    OP_EXG_AA,
    OP_EXG_DA,
    OP_ILLEGAL
  } op_kind_t;

  // Operand size codes, as in the AND opmode field.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  // Opmode codes of line C.
  localparam logic [2:0] OPM_AND_B_D = 3'd0;
  localparam logic [2:0] OPM_AND_W_D = 3'd1;
  localparam logic [2:0] OPM_AND_L_D = 3'd2;
  localparam logic [2:0] OPM_MULU    = 3'd3;
  localparam logic [2:0] OPM_AND_B_M = 3'd4;
  localparam logic [2:0] OPM_EXG_RR  = 3'd5;
  localparam logic [2:0] OPM_EXG_DA  = 3'd6;
  localparam logic [2:0] OPM_MULS    = 3'd7;

  // Effective address mode codes that the decoder singles out.
  localparam logic [2:0] MODE_DREG  = 3'd0;
  localparam logic [2:0] MODE_AREG  = 3'd1;
  localparam logic [2:0] MODE_OTHER = 3'd7;

  // Decoded instruction as held in the queue between front and back.
  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  size;
    logic [2:0]  rx;
    logic [2:0]  ry;
    logic        use_mem;
    logic [31:0] mem_operand;
  } qitem_t;

endpackage

/* rtl/mcx_front.sv */
// ----------------------------------------------------------------------------
// mcx_front: instruction accept and decode
// Takes instruction transfers while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module mcx_front
  import mcx_pkg::*;
(
  input  logic   in_valid,
  output logic   in_stall,
  input  in_t    in_data,
  input  logic   q_full,
  output logic   q_push,
  output qitem_t q_item
);

  logic [2:0] opm;
  logic [2:0] mode;
  logic [2:0] reg_f;
  logic       readable;
  logic       writable;

  assign opm   = in_data.opcode[8:6];
  assign mode  = in_data.opcode[5:3];
  assign reg_f = in_data.opcode[2:0];

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    readable = (mode != MODE_AREG);
    if (mode == MODE_OTHER) begin
      readable = (reg_f <= 3'd4);
    end
    writable = (mode != MODE_DREG) && (mode != MODE_AREG);
    if (mode == MODE_OTHER) begin
      writable = (reg_f <= 3'd1);
    end
  end

  always_comb begin
    q_item.size        = opm[1:0];
    q_item.rx          = in_data.opcode[11:9];
    q_item.ry          = reg_f;
    q_item.use_mem     = (mode != MODE_DREG);
    q_item.mem_operand = in_data.mem_operand;
    q_item.kind        = OP_ILLEGAL;
    unique case (opm)
      OPM_AND_B_D, OPM_AND_W_D, OPM_AND_L_D: begin
        q_item.kind = readable ? OP_AND_TO_D : OP_ILLEGAL;
      end
      OPM_MULU: begin
        q_item.kind = readable ? OP_MULU : OP_ILLEGAL;
      end
      OPM_MULS: begin
        q_item.kind = readable ? OP_MULS : OP_ILLEGAL;
      end
      OPM_EXG_RR: begin
        if (mode == MODE_DREG) begin
          q_item.kind = OP_EXG_DD;
        end else if (mode == MODE_AREG) begin
          q_item.kind = OP_EXG_AA;
        end else begin
          q_item.kind = writable ? OP_AND_TO_M : OP_ILLEGAL;
        end
      end
      OPM_EXG_DA: begin
        if (mode == MODE_AREG) begin
          q_item.kind = OP_EXG_DA;
        end else begin
          q_item.kind = writable ? OP_AND_TO_M : OP_ILLEGAL;
        end
      end
      default: begin
        q_item.kind = writable ? OP_AND_TO_M : OP_ILLEGAL;
      end
    endcase
  end

endmodule

/* rtl/mcx_queue.sv */
// ----------------------------------------------------------------------------
// mcx_queue: decoded instruction queue
// A small FIFO that parts the decoder from the execute stage.
// ----------------------------------------------------------------------------
module mcx_queue
  import mcx_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output qitem_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  qitem_t        store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_COUNT);
  assign not_empty = (count_r != '0);
  assign head_item = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/mcx_back.sv */
// ----------------------------------------------------------------------------
// mcx_back: execute stage with register file and result register
// Carries out one decoded instruction per cycle while the result side does not stall, and holds the result.
// ----------------------------------------------------------------------------
module mcx_back
  import mcx_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_not_empty,
  input  qitem_t q_item,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  logic [31:0] data_regs_r [8];
  logic [31:0] data_regs_nxt [8];
  logic [31:0] addr_regs_r [8];
  logic [31:0] addr_regs_nxt [8];
  logic [3:0]  flags_r, flags_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic        advance;
  logic [31:0] src;
  logic [31:0] dv;
  logic [31:0] mask;
  logic [31:0] and_res;
  logic        is_signed;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] mul_full;
  logic [31:0] prod;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: size_mask = 32'h0000_00ff;
      SZ_WORD: size_mask = 32'h0000_ffff;
      default: size_mask = 32'hffff_ffff;
    endcase
  endfunction

  // N and Z from the sized value; V and C are cleared.
  function automatic logic [3:0] nz_flags(input logic [31:0] v, input logic [1:0] sz);
    logic z;
    logic s;
    z = ((v & size_mask(sz)) == 32'd0);
    case (sz)
      SZ_BYTE: s = v[7];
      SZ_WORD: s = v[15];
      default: s = v[31];
    endcase
    nz_flags = {!z && s, z, 2'b00};
  endfunction

  assign advance   = !out_valid_r || !out_stall;
  assign q_pop     = q_not_empty && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dv        = data_regs_r[q_item.rx];
    src       = q_item.use_mem ? q_item.mem_operand : data_regs_r[q_item.ry];
    mask      = size_mask(q_item.size);
    and_res   = dv & src & mask;
    is_signed = (q_item.kind == OP_MULS);
    mul_a     = {is_signed & dv[15], dv[15:0]};
    mul_b     = {is_signed & src[15], src[15:0]};
    mul_full  = 34'($signed(mul_a) * $signed(mul_b));
    prod      = mul_full[31:0];
  end

  always_comb begin
    data_regs_nxt = data_regs_r;
    addr_regs_nxt = addr_regs_r;
    flags_nxt     = flags_r;
    if (q_pop) begin
      unique case (q_item.kind)
        OP_AND_TO_D: begin
          data_regs_nxt[q_item.rx] = (dv & ~mask) | and_res;
          flags_nxt = nz_flags(and_res, q_item.size);
        end
        OP_AND_TO_M: begin
          flags_nxt = nz_flags(and_res, q_item.size);
        end
        OP_MULU, OP_MULS: begin
          data_regs_nxt[q_item.rx] = prod;
          flags_nxt = nz_flags(prod, SZ_LONG);
        end
        OP_EXG_DD: begin
          data_regs_nxt[q_item.rx] = data_regs_r[q_item.ry];
          data_regs_nxt[q_item.ry] = dv;
        end
        OP_EXG_AA: begin
          addr_regs_nxt[q_item.rx] = addr_regs_r[q_item.ry];
          addr_regs_nxt[q_item.ry] = addr_regs_r[q_item.rx];
        end
        OP_EXG_DA: begin
          data_regs_nxt[q_item.rx] = addr_regs_r[q_item.ry];
          addr_regs_nxt[q_item.ry] = dv;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = advance ? q_not_empty : out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_data_nxt.illegal    = (q_item.kind == OP_ILLEGAL);
      out_data_nxt.mem_write  = (q_item.kind == OP_AND_TO_M);
      out_data_nxt.flags_nzvc = flags_nxt;
      case (q_item.kind)
        OP_AND_TO_D, OP_AND_TO_M: out_data_nxt.mem_data = and_res;
        OP_MULU, OP_MULS:         out_data_nxt.mem_data = prod;
        default:                  out_data_nxt.mem_data = 32'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        data_regs_r[i] <= 32'd0;
        addr_regs_r[i] <= 32'd0;
      end
      flags_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      data_regs_r <= data_regs_nxt;
      addr_regs_r <= addr_regs_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/m68k_line_c_mul_and_exg.sv */
// ----------------------------------------------------------------------------
// m68k_line_c_mul_and_exg: execute stage for 68000 instruction line C
// MULU.W, MULS.W, AND in all sizes and directions, and EXG, with the
// data registers, address registers and condition flags held inside.
// ----------------------------------------------------------------------------
// The block retires one instruction per clock cycle when neither side stalls.
// An accepted instruction is decoded at once and written into a small queue;
// the execute stage takes it from the head of the queue when it may advance,
// does the 16x16 multiply or the AND combinationally, updates the register
// file and the flags, and loads the result register. A result is therefore
// offered from the result register once its instruction has passed through
// the queue. The execute stage, with its one register-file update per cycle
// while the result side does not stall, sets the rate of one instruction per
// cycle. The queue lets the decoder keep taking instructions while a result
// waits to be taken, and in_stall rises only when the queue is full.
// Effective-address calculation, memory access and the illegal-instruction
// trap are outside the block: memory operands arrive already read, and a
// result with mem_write set carries the value to store back. An illegal
// encoding changes nothing and returns the unchanged flags.
// ----------------------------------------------------------------------------
module m68k_line_c_mul_and_exg
  import mcx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Decoder to queue.
  logic   q_push;
  logic   q_full;
  qitem_t q_push_item;

  // Queue to execute stage.
  logic   q_pop;
  logic   q_not_empty;
  qitem_t q_head_item;

  // The front end decodes each instruction on the cycle of its transfer.
  mcx_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // Decoded instructions wait here, in order, until the execute stage is free.
  mcx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item)
  );

  // The execute stage owns all architectural state and the result register.
  mcx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_head_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

/* rtl/mcx_checker.sv */
// ----------------------------------------------------------------------------
// mcx_checker: port-level checks for the line-C execute block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mcx_checker
  import mcx_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A held result must not change while it is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // An illegal encoding neither writes memory nor carries data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.illegal |-> !out_data.mem_write && out_data.mem_data == 32'd0)
    else $error("illegal result carries a write or data");

  // A memory write comes from AND, which clears V and C and sets Z on zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mem_write |->
      out_data.flags_nzvc[1:0] == 2'b00 &&
      ((out_data.mem_data == 32'd0) == out_data.flags_nzvc[2]))
    else $error("flags inconsistent with written data");

  // N and Z are never set together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.flags_nzvc[3] && out_data.flags_nzvc[2]))
    else $error("N and Z both set");

endmodule

bind m68k_line_c_mul_and_exg mcx_checker u_mcx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/m68k_line_c_mul_and_exg_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68k_line_c_mul_and_exg_tb: self-checking bench for the line-C execute stage
// Sends MULU.W, MULS.W, AND, EXG and illegal encodings through the instruction
// channel, with random gaps and result-side stalls. A predictor keeps its own
// copy of the data registers, address registers and flags, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module m68k_line_c_mul_and_exg_tb;
  import mcx_pkg::*;

  // Opmodes 5 and 6 double as AND.W and AND.L to memory when the EA mode
  // is neither a data nor an address register.
  localparam logic [2:0] OPM_AND_W_M = OPM_EXG_RR;
  localparam logic [2:0] OPM_AND_L_M = OPM_EXG_DA;

  // Effective address modes 2 to 6, named for the directed cases.
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;

  // Register field values under mode 7.
  localparam logic [2:0] M7_ABS_W    = 3'd0;
  localparam logic [2:0] M7_ABS_L    = 3'd1;
  localparam logic [2:0] M7_PC_DISP  = 3'd2;
  localparam logic [2:0] M7_PC_INDEX = 3'd3;
  localparam logic [2:0] M7_IMM      = 3'd4;
  localparam logic [2:0] M7_RSVD_LO  = 3'd5;
  localparam logic [2:0] M7_RSVD_HI  = 3'd7;

  localparam logic [3:0] LINE_C = 4'hc;

  // Limit on quiet cycles, with no transfer on either channel, before the
  // watchdog gives up; it lies well above the longest stall or gap the bench makes.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to keep watching for stray results once everything has arrived.
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Shadow of the architectural state, in step with the block after each
  // accepted instruction.
  logic [31:0] dreg_shadow [8] = '{default: '0};
  logic [31:0] areg_shadow [8] = '{default: '0};
  logic [3:0]  ccr_shadow = '0;

  // Predicted results, oldest first.
  out_t pending_results [$];

  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  // When clear, neither side inserts gaps or stalls.
  logic idle_on = 1'b1;

  m68k_line_c_mul_and_exg dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [31:0] size_mask(logic [1:0] sz);
    case (sz)
      SZ_BYTE: return 32'h0000_00ff;
      SZ_WORD: return 32'h0000_ffff;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // N and Z from the sized result; V and C always end up clear.
  function automatic logic [3:0] nz_flags(logic [31:0] v, logic [1:0] sz);
    logic [31:0] mask;
    logic [31:0] sign;
    mask = size_mask(sz);
    sign = (mask >> 1) + 32'd1;
    if ((v & mask) == '0) return 4'b0100;
    if ((v & sign) != '0) return 4'b1000;
    return 4'b0000;
  endfunction

  // Executes one instruction on the shadow state and returns the result
  // that the block should give for it. Bits 15..12 play no part.
  function automatic out_t exec_line_c(logic [15:0] op, logic [31:0] mem);
    logic [2:0]         rx;
    logic [2:0]         opm;
    logic [2:0]         mode;
    logic [2:0]         ry;
    logic [1:0]         sz;
    logic [31:0]        src;
    logic [31:0]        mask;
    logic [31:0]        val;
    logic [31:0]        tmp;
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic               rd_ok;
    logic               wr_ok;
    out_t               res;
    rx   = op[11:9];
    opm  = op[8:6];
    mode = op[5:3];
    ry   = op[2:0];
    // A register-direct source ignores the memory operand.
    src  = (mode == MODE_DREG) ? dreg_shadow[ry] : mem;
    // Mode 7 can be read with registers up to the immediate and written
    // only as an absolute address.
    rd_ok = (mode == MODE_OTHER) ? (ry <= M7_IMM) : (mode != MODE_AREG);
    wr_ok = (mode == MODE_OTHER) ? (ry <= M7_ABS_L) :
            (mode != MODE_DREG && mode != MODE_AREG);
    res = '0;
    if (opm == OPM_AND_B_D || opm == OPM_AND_W_D || opm == OPM_AND_L_D) begin
      if (!rd_ok) begin
        res.illegal = 1'b1;
      end else begin
        sz   = opm[1:0];
        mask = size_mask(sz);
        val  = dreg_shadow[rx] & src & mask;
        // Byte and word writes leave the upper part of Dn alone.
        dreg_shadow[rx] = (dreg_shadow[rx] & ~mask) | val;
        ccr_shadow      = nz_flags(val, sz);
        res.mem_data    = val;
      end
    end else if (opm == OPM_MULU || opm == OPM_MULS) begin
      if (!rd_ok) begin
        res.illegal = 1'b1;
      end else begin
        if (opm == OPM_MULU) begin
          val = 32'(dreg_shadow[rx][15:0]) * 32'(src[15:0]);
        end else begin
          fa  = dreg_shadow[rx][15:0];
          fb  = src[15:0];
          val = fa * fb;
        end
        dreg_shadow[rx] = val;
        ccr_shadow      = nz_flags(val, SZ_LONG);
        res.mem_data    = val;
      end
    end else if (opm == OPM_EXG_RR && mode == MODE_DREG) begin
      tmp             = dreg_shadow[rx];
      dreg_shadow[rx] = dreg_shadow[ry];
      dreg_shadow[ry] = tmp;
    end else if (opm == OPM_EXG_RR && mode == MODE_AREG) begin
      tmp             = areg_shadow[rx];
      areg_shadow[rx] = areg_shadow[ry];
      areg_shadow[ry] = tmp;
    end else if (opm == OPM_EXG_DA && mode == MODE_AREG) begin
      tmp             = dreg_shadow[rx];
      dreg_shadow[rx] = areg_shadow[ry];
      areg_shadow[ry] = tmp;
    end else begin
      // AND Dn to memory. This also covers ABCD and opmode 6 with a data
      // register, which fail the writability test.
      if (!wr_ok) begin
        res.illegal = 1'b1;
      end else begin
        sz            = opm[1:0];
        val           = mem & dreg_shadow[rx] & size_mask(sz);
        ccr_shadow    = nz_flags(val, sz);
        res.mem_write = 1'b1;
        res.mem_data  = val;
      end
    end
    res.flags_nzvc = ccr_shadow;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle stretches are mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] line_c(logic [2:0] rx, logic [2:0] opm,
                                         logic [2:0] mode, logic [2:0] ry);
    return {LINE_C, rx, opm, mode, ry};
  endfunction

  // Offers one instruction and returns at the edge where it is taken, with
  // in_valid still high. Valid is lowered only when a gap follows, so that a
  // back-to-back transfer never sees valid dropped and raised in one step.
  task automatic issue_instr(input logic [15:0] op, input logic [31:0] mem);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, mem_operand: mem};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(exec_line_c(op, mem));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // AND into a data register in all three sizes, from a register, from
  // memory and from an immediate, with all-ones and all-zeros operands.
  task automatic test_and_to_reg();
    issue_instr(line_c(3'd0, OPM_AND_B_D, MODE_DREG, 3'd7), 32'hffff_ffff);
    issue_instr(line_c(3'd7, OPM_AND_W_D, MODE_IND, 3'd0), 32'hffff_ffff);
    issue_instr(line_c(3'd3, OPM_AND_L_D, MODE_OTHER, M7_IMM), 32'h0000_0000);
    issue_instr(line_c(3'd5, OPM_AND_B_D, MODE_INDEX, 3'd2), 32'h0000_0080);
  endtask

  // Both multiplies, with the most negative and all-ones word operands.
  task automatic test_mul();
    issue_instr(line_c(3'd0, OPM_MULU, MODE_DREG, 3'd0), 32'h0000_0000);
    issue_instr(line_c(3'd7, OPM_MULS, MODE_OTHER, M7_IMM), 32'h0000_8000);
    issue_instr(line_c(3'd2, OPM_MULU, MODE_POSTINC, 3'd5), 32'hffff_ffff);
    issue_instr(line_c(3'd6, OPM_MULS, MODE_OTHER, M7_PC_INDEX), 32'h7fff_ffff);
  endtask

  // AND to memory in all sizes, including both absolute forms.
  task automatic test_and_to_mem();
    issue_instr(line_c(3'd1, OPM_AND_B_M, MODE_PREDEC, 3'd3), 32'hffff_ffff);
    issue_instr(line_c(3'd4, OPM_AND_W_M, MODE_DISP, 3'd6), 32'h0000_8000);
    issue_instr(line_c(3'd6, OPM_AND_L_M, MODE_OTHER, M7_ABS_L), 32'h8000_0000);
    issue_instr(line_c(3'd2, OPM_AND_B_M, MODE_OTHER, M7_ABS_W), 32'h0000_0000);
  endtask

  // The three exchange forms; the flags must come back untouched.
  task automatic test_exg();
    issue_instr(line_c(3'd1, OPM_EXG_RR, MODE_DREG, 3'd6), 32'hffff_ffff);
    issue_instr(line_c(3'd4, OPM_EXG_RR, MODE_AREG, 3'd4), 32'h0000_0000);
    issue_instr(line_c(3'd7, OPM_EXG_DA, MODE_AREG, 3'd0), 32'hffff_ffff);
  endtask

  // Every class of unimplemented encoding, then the two opcode extremes to
  // show that the line bits are ignored.
  task automatic test_illegal_encodings();
    issue_instr(line_c(3'd0, OPM_AND_B_M, MODE_DREG, 3'd1), 32'hffff_ffff);
    issue_instr(line_c(3'd3, OPM_AND_B_M, MODE_AREG, 3'd2), 32'hffff_ffff);
    issue_instr(line_c(3'd5, OPM_EXG_DA, MODE_DREG, 3'd5), 32'hffff_ffff);
    issue_instr(line_c(3'd2, OPM_AND_L_D, MODE_AREG, 3'd3), 32'hffff_ffff);
    issue_instr(line_c(3'd6, OPM_MULS, MODE_AREG, 3'd7), 32'hffff_ffff);
    issue_instr(line_c(3'd1, OPM_AND_L_M, MODE_OTHER, M7_PC_DISP), 32'hffff_ffff);
    issue_instr(line_c(3'd4, OPM_AND_B_M, MODE_OTHER, M7_RSVD_HI), 32'hffff_ffff);
    issue_instr(line_c(3'd7, OPM_AND_W_D, MODE_OTHER, M7_RSVD_LO), 32'hffff_ffff);
    issue_instr(line_c(3'd0, OPM_MULU, MODE_OTHER, M7_RSVD_HI), 32'hffff_ffff);
    issue_instr(16'h0000, 32'h0000_0000);
    issue_instr(16'hffff, 32'hffff_ffff);
  endtask

  // --------------------------------------------------------------------------
  // Random test
  // --------------------------------------------------------------------------

  // Mostly well-formed instructions with random registers and operands; the
  // rest are fully random words, which land on the illegal encodings often.
  task automatic test_random_mix(input int count);
    logic [3:0]  top;
    logic [2:0]  rx;
    logic [2:0]  opm;
    logic [2:0]  mode;
    logic [2:0]  ry;
    logic [31:0] mem;
    for (int i = 0; i < count; i++) begin
      top  = 4'($urandom);
      rx   = 3'($urandom);
      ry   = 3'($urandom);
      opm  = 3'($urandom);
      mode = 3'($urandom);
      mem  = $urandom;
      case ($urandom_range(0, 7))
        0: mem = '0;
        1: mem = '1;
        2: mem = {16'($urandom), 16'h8000};
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // AND into Dn or a multiply, from any readable source.
          opm = 3'($urandom_range(OPM_AND_B_D, OPM_AND_B_M));
          if (opm == OPM_AND_B_M) opm = OPM_MULS;
          mode = 3'($urandom_range(MODE_DREG, MODE_OTHER));
          if (mode == MODE_AREG) mode = MODE_DREG;
          if (mode == MODE_OTHER) ry = 3'($urandom_range(M7_ABS_W, M7_IMM));
        end
        3, 4: begin
          // AND to a writable memory operand.
          opm  = 3'($urandom_range(OPM_AND_B_M, OPM_AND_L_M));
          mode = 3'($urandom_range(MODE_IND, MODE_OTHER));
          if (mode == MODE_OTHER) ry = 3'($urandom_range(M7_ABS_W, M7_ABS_L));
        end
        5: begin
          case ($urandom_range(0, 2))
            0: begin
              opm  = OPM_EXG_RR;
              mode = MODE_DREG;
            end
            1: begin
              opm  = OPM_EXG_RR;
              mode = MODE_AREG;
            end
            default: begin
              opm  = OPM_EXG_DA;
              mode = MODE_AREG;
            end
          endcase
        end
        default: ;
      endcase
      issue_instr({top, rx, opm, mode, ry}, mem);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Result stalls come in bursts of the same lengths as the input gaps.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= idle_len() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result transfer is matched against the oldest prediction. Values
  // read here are those from before the edge, as the block saw them.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no instruction outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.illegal !== want.illegal) begin
          $error("illegal: expected %b, got %b", want.illegal, out_data.illegal);
          fail_count++;
        end
        if (out_data.mem_write !== want.mem_write) begin
          $error("mem_write: expected %b, got %b", want.mem_write, out_data.mem_write);
          fail_count++;
        end
        if (out_data.mem_data !== want.mem_data) begin
          $error("mem_data: expected %h, got %h", want.mem_data, out_data.mem_data);
          fail_count++;
        end
        if (out_data.flags_nzvc !== want.flags_nzvc) begin
          $error("flags_nzvc: expected %b, got %b", want.flags_nzvc, out_data.flags_nzvc);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a run in which no transfer happens for too long has hung, for
  // example because a result never arrived.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_and_to_reg();
    test_mul();
    test_and_to_mem();
    test_exg();
    test_illegal_encodings();

    // Random traffic with idling, then a stretch at full rate on both sides,
    // then idling again.
    test_random_mix(600);
    idle_on <= 1'b0;
    test_random_mix(250);
    idle_on <= 1'b1;
    test_random_mix(600);

    // The last instruction has just been taken; drop valid and let the
    // remaining results come out.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
